// ===== rtl/zbps_pkg.sv =====
// ----------------------------------------------------------------------------
// zbps_pkg
// Shared widths, constants and control types for the z-buffered point splatter.
// ----------------------------------------------------------------------------
package zbps_pkg;

  // Screen grid
  localparam int SCREEN_WIDTH  = 90;
  localparam int SCREEN_HEIGHT = 30;
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int HALF_W        = SCREEN_WIDTH / 2;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;

  // Field widths
  localparam int POS_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CAM_W   = 15;
  localparam int CELL_W  = 12;
  localparam int SHADE_W = 4;
  localparam int DEPTH_W = 16;
  localparam int IDX_W   = 3;

  // Internal arithmetic widths
  localparam int ROT_W  = 18;   // rotated coordinate, Q4.12 / Q2.14
  localparam int ACC_W  = 36;   // multiply-accumulate
  localparam int LIT_W  = 29;   // clamped lighting, 0 .. 2^28
  localparam int Z_W    = 19;   // shifted depth, Q4.12
  localparam int NUM_W  = 27;   // projection numerators
  localparam int DVD_W  = 29;   // divider dividend
  localparam int DVS_W  = 18;   // divider divisor
  localparam int MEM_W  = DEPTH_W + SHADE_W;

  localparam logic [4:0]         MAC_LAST    = 5'd18;
  localparam logic [SHADE_W-1:0] SHADE_BLANK = 4'd15;
  localparam logic [SHADE_W-1:0] SHADE_MAX   = 4'd11;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COS_A   = 3'd0,
    REG_SIN_A   = 3'd1,
    REG_COS_B   = 3'd2,
    REG_SIN_B   = 3'd3,
    REG_LIGHT_X = 3'd4,
    REG_LIGHT_Y = 3'd5,
    REG_LIGHT_Z = 3'd6,
    REG_CAM_OFS = 3'd7
  } cfg_reg_t;

  // Which quotient the divider is producing
  localparam logic [1:0] DSEL_IZ = 2'd0;
  localparam logic [1:0] DSEL_X  = 2'd1;
  localparam logic [1:0] DSEL_Y  = 2'd2;

  // Memory read address source
  localparam logic MRD_CELL = 1'b0;
  localparam logic MRD_RC   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              mac_en;
    logic [4:0]        mac_step;
    logic              prep;
    logic              zchk;
    logic              div_start;
    logic [1:0]        div_arg;
    logic              div_cap;
    logic [1:0]        div_sel;
    logic              cell_en;
    logic              mem_rd;
    logic              mem_rd_sel;
    logic              upd;
    logic              rd_out;
    logic              drop;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic too_close;
    logic div_done;
    logic off;
  } sts_t;

endpackage

// ===== rtl/zbps_div.sv =====
// ----------------------------------------------------------------------------
// zbps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zbps_div
  import zbps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             done,
  output logic [DVD_W-1:0] quo
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step
  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dvd;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DVD_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= dvs;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/zbps_ctrl.sv =====
// ----------------------------------------------------------------------------
// zbps_ctrl
// Sequencer: memory clear, multiply-accumulate steps, divides, z-buffer access.
// ----------------------------------------------------------------------------
module zbps_ctrl
  import zbps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_req_type,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_MAC   = 11'b000_0000_0100,
    ST_PREP  = 11'b000_0000_1000,
    ST_ZCHK  = 11'b000_0001_0000,
    ST_DIV   = 11'b000_0010_0000,
    ST_CELL  = 11'b000_0100_0000,
    ST_MEMRD = 11'b000_1000_0000,
    ST_UPD   = 11'b001_0000_0000,
    ST_RDMEM = 11'b010_0000_0000,
    ST_RDOUT = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [1:0]        dsel_r, dsel_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    dsel_nxt     = dsel_r;
    clr_nxt      = clr_r;
    cmd          = '0;
    cmd.clr_addr = clr_r;
    cmd.mac_step = step_r;
    cmd.div_sel  = dsel_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_req_type) begin
            state_nxt = ST_RDMEM;
          end else begin
            state_nxt = ST_MAC;
            step_nxt  = '0;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (step_r == MAC_LAST) begin
          state_nxt = ST_PREP;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_ZCHK;
      end
      ST_ZCHK: begin
        cmd.zchk = 1'b1;
        if (sts.too_close) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_arg   = DSEL_IZ;
          dsel_nxt      = DSEL_IZ;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          if (dsel_r == DSEL_Y) begin
            state_nxt = ST_CELL;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_arg   = dsel_r + 1'b1;
            dsel_nxt      = dsel_r + 1'b1;
          end
        end
      end
      ST_CELL: begin
        cmd.cell_en = 1'b1;
        state_nxt   = ST_MEMRD;
      end
      ST_MEMRD: begin
        if (sts.off) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.mem_rd     = 1'b1;
          cmd.mem_rd_sel = MRD_CELL;
          state_nxt      = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RDMEM: begin
        cmd.mem_rd     = 1'b1;
        cmd.mem_rd_sel = MRD_RC;
        state_nxt      = ST_RDOUT;
      end
      ST_RDOUT: begin
        cmd.rd_out = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
      dsel_r  <= DSEL_IZ;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dsel_r  <= dsel_nxt;
      clr_r   <= clr_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/zbps_dp.sv =====
// ----------------------------------------------------------------------------
// zbps_dp
// Datapath: config registers, shared multiplier, projection, divider, z-buffer.
// ----------------------------------------------------------------------------
module zbps_dp
  import zbps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_idx,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_req_type,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic signed [POS_W-1:0]  in_norm_x,
  input  logic signed [POS_W-1:0]  in_norm_y,
  input  logic signed [POS_W-1:0]  in_norm_z,
  input  logic [CELL_W-1:0]        in_read_cell,
  output logic                     out_valid,
  output logic [CELL_W-1:0]        out_cell_out,
  output logic                     out_off_screen,
  output logic                     out_was_written,
  output logic [SHADE_W-1:0]       out_shade_level,
  output logic [DEPTH_W-1:0]       out_depth_out
);

  localparam logic signed [Z_W-1:0] Z_NEAR  = Z_W'(256);
  localparam logic [DVD_W-1:0]      IZ_NUM  = DVD_W'(1 << 28);
  localparam logic signed [ACC_W:0] LIT_OFS = (ACC_W + 1)'(1 << 28);
  localparam logic signed [ACC_W:0] LIT_TOP = (ACC_W + 1)'(1 << 28);

  // Configuration registers
  logic signed [CFG_W-1:0] cos_a_r, sin_a_r, cos_b_r, sin_b_r;
  logic signed [CFG_W-1:0] lx_r, ly_r, lz_r;
  logic [CAM_W-1:0]        cam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_a_r <= 16'sd16384;
      sin_a_r <= '0;
      cos_b_r <= 16'sd16384;
      sin_b_r <= '0;
      lx_r    <= -16'sd6554;
      ly_r    <= 16'sd9830;
      lz_r    <= 16'sd16384;
      cam_r   <= 15'd28672;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_COS_A:   cos_a_r <= cfg_wdata;
        REG_SIN_A:   sin_a_r <= cfg_wdata;
        REG_COS_B:   cos_b_r <= cfg_wdata;
        REG_SIN_B:   sin_b_r <= cfg_wdata;
        REG_LIGHT_X: lx_r    <= cfg_wdata;
        REG_LIGHT_Y: ly_r    <= cfg_wdata;
        REG_LIGHT_Z: lz_r    <= cfg_wdata;
        REG_CAM_OFS: cam_r   <= cfg_wdata[CAM_W-1:0];
        default:     cam_r   <= cam_r;
      endcase
    end
  end

  // Request capture
  logic signed [POS_W-1:0] px_r, py_r, pz_r, nx_r, ny_r, nz_r;
  logic [CELL_W-1:0]       rc_r;
  logic                    req_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      pz_r  <= in_pos_z;
      nx_r  <= in_norm_x;
      ny_r  <= in_norm_y;
      nz_r  <= in_norm_z;
      rc_r  <= in_read_cell;
    end
  end

  // Rotation results for the point (p) and the normal (n)
  logic signed [ROT_W-1:0] py1_r, pz1_r, px2_r, pz2_r;
  logic signed [ROT_W-1:0] ny1_r, nz1_r, nx2_r, nz2_r;
  logic signed [ACC_W-1:0] acc_r;

  // Multiply-accumulate step decode
  logic                    set_n;
  logic signed [ROT_W-1:0] vx, vy, vz, vz1;
  logic signed [ROT_W-1:0] a_op;
  logic signed [CFG_W-1:0] b_op;
  logic                    first, neg, dst_en;
  logic [1:0]              dst;
  logic signed [ACC_W-1:0] prod, sum;
  logic signed [ROT_W-1:0] rot_val;

  always_comb begin
    set_n  = cmd.mac_step[3];
    vx     = set_n ? ROT_W'(nx_r) : ROT_W'(px_r);
    vy     = set_n ? ROT_W'(ny_r) : ROT_W'(py_r);
    vz     = set_n ? ROT_W'(nz_r) : ROT_W'(pz_r);
    vz1    = set_n ? nz1_r : pz1_r;
    a_op   = vy;
    b_op   = cos_a_r;
    first  = 1'b0;
    neg    = 1'b0;
    dst_en = 1'b0;
    dst    = 2'd0;
    if (cmd.mac_step[4]) begin
      // dot product with the light vector
      case (cmd.mac_step[1:0])
        2'd0: begin
          a_op  = nx2_r;
          b_op  = lx_r;
          first = 1'b1;
        end
        2'd1: begin
          a_op = ny1_r;
          b_op = ly_r;
        end
        default: begin
          a_op = nz2_r;
          b_op = lz_r;
        end
      endcase
    end else begin
      case (cmd.mac_step[2:0])
        3'd0: begin
          a_op = vy; b_op = cos_a_r; first = 1'b1;
        end
        3'd1: begin
          a_op = vz; b_op = sin_a_r; neg = 1'b1; dst_en = 1'b1; dst = 2'd0;
        end
        3'd2: begin
          a_op = vy; b_op = sin_a_r; first = 1'b1;
        end
        3'd3: begin
          a_op = vz; b_op = cos_a_r; dst_en = 1'b1; dst = 2'd1;
        end
        3'd4: begin
          a_op = vx; b_op = cos_b_r; first = 1'b1;
        end
        3'd5: begin
          a_op = vz1; b_op = sin_b_r; dst_en = 1'b1; dst = 2'd2;
        end
        3'd6: begin
          a_op = vz1; b_op = cos_b_r; first = 1'b1;
        end
        default: begin
          a_op = vx; b_op = sin_b_r; neg = 1'b1; dst_en = 1'b1; dst = 2'd3;
        end
      endcase
    end
  end

  assign prod    = a_op * b_op;
  assign sum     = (first ? '0 : acc_r) + (neg ? -prod : prod);
  assign rot_val = sum[ROT_W+13:14];

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc_r <= sum;
      if (dst_en) begin
        case ({set_n, dst})
          3'd0:    py1_r <= rot_val;
          3'd1:    pz1_r <= rot_val;
          3'd2:    px2_r <= rot_val;
          3'd3:    pz2_r <= rot_val;
          3'd4:    ny1_r <= rot_val;
          3'd5:    nz1_r <= rot_val;
          3'd6:    nx2_r <= rot_val;
          default: nz2_r <= rot_val;
        endcase
      end
    end
  end

  // Lighting bias and clamp, shifted depth
  logic signed [ACC_W:0]  lit_t, lit_h;
  logic [LIT_W-1:0]       lit_r;
  logic signed [Z_W-1:0]  zz_r;

  always_comb begin
    lit_t = (ACC_W + 1)'(acc_r) + LIT_OFS;
    lit_h = lit_t >>> 1;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (lit_h < 0) begin
        lit_r <= '0;
      end else if (lit_h > LIT_TOP) begin
        lit_r <= LIT_TOP[LIT_W-1:0];
      end else begin
        lit_r <= lit_h[LIT_W-1:0];
      end
      zz_r <= Z_W'(pz2_r) + Z_W'(cam_r);
    end
  end

  // Projection numerators
  logic signed [NUM_W-1:0] numx_r, numy_r;
  logic [NUM_W-1:0]        absx, absy;

  always_ff @(posedge clk) begin
    if (cmd.zchk) begin
      numx_r <= NUM_W'(zz_r) * NUM_W'(HALF_W) + (NUM_W'(px2_r) <<< 5);
      numy_r <= NUM_W'(zz_r) * NUM_W'(HALF_H) - NUM_W'(py1_r) * NUM_W'(18);
    end
  end

  assign absx = numx_r[NUM_W-1] ? -numx_r : numx_r;
  assign absy = numy_r[NUM_W-1] ? -numy_r : numy_r;

  // Shared divider
  logic [DVD_W-1:0] dvd, quo;
  logic             div_done;

  always_comb begin
    case (cmd.div_arg)
      DSEL_IZ: dvd = IZ_NUM;
      DSEL_X:  dvd = DVD_W'(absx);
      default: dvd = DVD_W'(absy);
    endcase
  end

  zbps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (dvd),
    .dvs   (zz_r[DVS_W-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  // Quotient capture: inverse depth, column, row
  logic [DEPTH_W-1:0] iz_r;
  logic               x_ok_r, y_ok_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.div_sel)
        DSEL_IZ: begin
          iz_r <= (quo > DVD_W'(16'hFFFF)) ? 16'hFFFF : quo[DEPTH_W-1:0];
        end
        DSEL_X: begin
          x_ok_r <= (!numx_r[NUM_W-1] && (quo < DVD_W'(SCREEN_WIDTH))) || (quo == '0);
          col_r  <= COL_W'(quo);
        end
        default: begin
          y_ok_r <= (!numy_r[NUM_W-1] && (quo < DVD_W'(SCREEN_HEIGHT))) || (quo == '0);
          row_r  <= ROW_W'(quo);
        end
      endcase
    end
  end

  // Cell index and shade level
  logic [ADDR_W-1:0]  cell_r;
  logic               off_r;
  logic [SHADE_W-1:0] shade_r;
  logic [31:0]        lit11;

  assign lit11 = {lit_r, 3'b000} + {2'b00, lit_r, 1'b0} + {3'b000, lit_r};

  always_ff @(posedge clk) begin
    if (cmd.cell_en) begin
      cell_r  <= ADDR_W'(col_r) + ADDR_W'(row_r * SCREEN_WIDTH);
      off_r   <= !(x_ok_r && y_ok_r);
      shade_r <= (lit11[31:28] > SHADE_MAX) ? SHADE_MAX : lit11[31:28];
    end
  end

  // Z-buffer memory: {depth, shade}
  logic [MEM_W-1:0]  mem [CELLS];
  logic [MEM_W-1:0]  mem_q_r;
  logic              rc_ok;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [MEM_W-1:0]  wr_data;
  logic [DEPTH_W-1:0] old_depth;
  logic               pass;

  assign rc_ok     = (rc_r < CELL_W'(CELLS));
  assign rd_addr   = (cmd.mem_rd_sel == MRD_RC) ? ADDR_W'(rc_r) : cell_r;
  assign mem_re    = cmd.mem_rd && ((cmd.mem_rd_sel == MRD_CELL) || rc_ok);
  assign old_depth = mem_q_r[MEM_W-1:SHADE_W];
  assign pass      = (iz_r > old_depth);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cmd.clr_addr;
    wr_data = {{DEPTH_W{1'b0}}, SHADE_BLANK};
    if (cmd.clr_we) begin
      mem_we = 1'b1;
    end else if (cmd.upd && pass) begin
      mem_we  = 1'b1;
      wr_addr = cell_r;
      wr_data = {iz_r, shade_r};
    end else if (cmd.rd_out && rc_ok) begin
      mem_we  = 1'b1;
      wr_addr = ADDR_W'(rc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Result register
  logic                out_valid_r;
  logic [CELL_W-1:0]   out_cell_r;
  logic                out_off_r, out_wr_r;
  logic [SHADE_W-1:0]  out_shade_r;
  logic [DEPTH_W-1:0]  out_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.upd || cmd.rd_out || cmd.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop) begin
      out_cell_r  <= '0;
      out_off_r   <= 1'b1;
      out_wr_r    <= 1'b0;
      out_shade_r <= SHADE_BLANK;
      out_depth_r <= '0;
    end else if (cmd.upd) begin
      out_cell_r  <= CELL_W'(cell_r);
      out_off_r   <= 1'b0;
      out_wr_r    <= pass;
      out_shade_r <= pass ? shade_r : mem_q_r[SHADE_W-1:0];
      out_depth_r <= pass ? iz_r : old_depth;
    end else if (cmd.rd_out) begin
      out_cell_r  <= rc_r;
      out_off_r   <= 1'b0;
      out_wr_r    <= 1'b0;
      out_shade_r <= rc_ok ? mem_q_r[SHADE_W-1:0] : SHADE_BLANK;
      out_depth_r <= rc_ok ? old_depth : '0;
    end
  end

  // Status back to the controller; req_r kept for read/plot bookkeeping
  assign sts.too_close = (zz_r <= Z_NEAR) && !req_r;
  assign sts.div_done  = div_done;
  assign sts.off       = off_r;

  assign out_valid       = out_valid_r;
  assign out_cell_out    = out_cell_r;
  assign out_off_screen  = out_off_r;
  assign out_was_written = out_wr_r;
  assign out_shade_level = out_shade_r;
  assign out_depth_out   = out_depth_r;

endmodule

// ===== rtl/zbuffered_point_splatter_top.sv =====
// ----------------------------------------------------------------------------
// zbuffered_point_splatter_top
// Rotates, lights and projects surface points into a z-buffered cell grid.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid, and must be captured
// then, as there is no back-pressure. A plot keeps busy high through 19 steps
// on the one shared multiplier, a lighting and depth step, a near check, then
// three runs of the bit-per-cycle divider (inverse depth, column, row), then
// the cell index and the read-modify-write of the z-buffer RAM. A point
// dropped as too close leaves busy after the near check, one that lands off
// screen after the cell index. A read-and-clear reads the cell and then, if it
// is on the grid, writes it blank. Every result shows in the first cycle with
// busy low. After reset the block stays busy while it clears the z-buffer, one
// cell per cycle; configuration writes are taken at any time while busy is
// low.
module zbuffered_point_splatter_top
  import zbps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic signed [POS_W-1:0]  in_norm_x,
  input  logic signed [POS_W-1:0]  in_norm_y,
  input  logic signed [POS_W-1:0]  in_norm_z,
  input  logic [CELL_W-1:0]        in_read_cell,
  output logic                     out_valid,
  output logic [CELL_W-1:0]        out_cell_out,
  output logic                     out_off_screen,
  output logic                     out_was_written,
  output logic [SHADE_W-1:0]       out_shade_level,
  output logic [DEPTH_W-1:0]       out_depth_out,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_idx,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  zbps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  zbps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_norm_x       (in_norm_x),
    .in_norm_y       (in_norm_y),
    .in_norm_z       (in_norm_z),
    .in_read_cell    (in_read_cell),
    .out_valid       (out_valid),
    .out_cell_out    (out_cell_out),
    .out_off_screen  (out_off_screen),
    .out_was_written (out_was_written),
    .out_shade_level (out_shade_level),
    .out_depth_out   (out_depth_out)
  );

`ifndef SYNTH
  // An accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");

  // A result is only presented once the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result presented while busy");

  // A depth-test pass is on screen and stores a non-zero inverse depth
  a_written_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_written) |-> (!out_off_screen && (out_depth_out != '0)))
    else $error("written cell with bad flags or zero depth");

  // The divider only finishes while a plot is in progress
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> busy) else $error("divider done while idle");
`endif

endmodule
